@@ rtl/core/move_with_extend_execute_unit_macros.svh @@
// Assertion macros for the move-with-extend execute unit.
// Included by the top level; no other dependencies.
`ifndef MOVE_WITH_EXTEND_EXECUTE_UNIT_MACROS_SVH
`define MOVE_WITH_EXTEND_EXECUTE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MWEU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mweu assertion failed");
// next-cycle implication
`define MWEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mweu assertion failed");
`else
`define MWEU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MWEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/mweu_pkg.sv @@
// Package for the move-with-extend execute unit: item codes, addressing
// mode codes and extension helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mweu_pkg;

  // item kinds on the input channel
  localparam logic [1:0] OP_WRITE_REG   = 2'd0;
  localparam logic [1:0] OP_EXECUTE     = 2'd1;
  localparam logic [1:0] OP_DATA_RETURN = 2'd2;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_MEM_READ    = 3'd1,
    ST_UNHANDLED   = 3'd2,
    ST_REG_WRITTEN = 3'd3,
    ST_IGNORED     = 3'd4
  } status_t;

  // instruction match: 0111 ddd 1 oo eeeeee
  localparam logic [15:0] OPC_MASK  = 16'hF100;
  localparam logic [15:0] OPC_MATCH = 16'h7100;

  // effective address mode field
  localparam logic [2:0] EA_DREG    = 3'd0;
  localparam logic [2:0] EA_AREG    = 3'd1;
  localparam logic [2:0] EA_IND     = 3'd2;
  localparam logic [2:0] EA_POSTINC = 3'd3;
  localparam logic [2:0] EA_PREDEC  = 3'd4;
  localparam logic [2:0] EA_DISP    = 3'd5;
  localparam logic [2:0] EA_INDEX   = 3'd6;
  localparam logic [2:0] EA_SPECIAL = 3'd7;

  // register field under the special mode
  localparam logic [2:0] EA7_ABS_W    = 3'd0;
  localparam logic [2:0] EA7_ABS_L    = 3'd1;
  localparam logic [2:0] EA7_PC_DISP  = 3'd2;
  localparam logic [2:0] EA7_PC_INDEX = 3'd3;
  localparam logic [2:0] EA7_IMM      = 3'd4;

  // extend kinds (oo field)
  localparam logic [1:0] EXT_MVS_B = 2'd0;
  localparam logic [1:0] EXT_MVS_W = 2'd1;
  localparam logic [1:0] EXT_MVZ_B = 2'd2;
  localparam logic [1:0] EXT_MVZ_W = 2'd3;

  localparam logic [4:0] REG_INDEX_CC = 5'd16;
  localparam int unsigned CC_X_BIT = 4;

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] extend_value(input logic [1:0] kind,
                                               input logic [31:0] src);
    logic [31:0] r;
    unique case (kind)
      EXT_MVS_B: r = sx8(src[7:0]);
      EXT_MVS_W: r = sx16(src[15:0]);
      EXT_MVZ_B: r = {24'd0, src[7:0]};
      EXT_MVZ_W: r = {16'd0, src[15:0]};
      default:   r = src;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/move_with_extend_execute_unit.sv @@
// Move-with-extend execute unit (MVS/MVZ into a data register), top level.
// Depends on mweu_pkg and move_with_extend_execute_unit_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | opcode, instr word, ext words, pc, data, reg
//  out     | out_valid / out_stall | status, read request, Dn write, flags, pc, An
//
// One item per cycle sustained while out_stall is low. An accepted item is held in the input
// register (register file read ports are registered there, with write bypass),
// is decoded and executed in one pass, and lands in the output register.
// The result reaches out_valid through the input register and then the output register.
// Synchronous active-low reset clears the valid flags, register-file valid bits,
// condition codes and the pending-read state; registers not yet written read 0.
// A stalled output holds the input stage; in_stall rises only when both stages
// are full and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

`include "move_with_extend_execute_unit_macros.svh"

module move_with_extend_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_instr_word,
  input  wire logic [15:0] in_ext_word_first,
  input  wire logic [15:0] in_ext_word_second,
  input  wire logic [31:0] in_ext_addr,
  input  wire logic [15:0] in_mem_data,
  input  wire logic [4:0]  in_reg_index,
  input  wire logic [31:0] in_reg_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_mem_address,
  output logic             out_mem_byte,
  output logic [2:0]       out_dest_reg,
  output logic [31:0]      out_dest_value,
  output logic [4:0]       out_cond_codes,
  output logic [31:0]      out_next_pc,
  output logic [2:0]       out_addr_reg_index,
  output logic [31:0]      out_addr_reg_value,
  output logic             out_addr_reg_changed
);
  import mweu_pkg::*;

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic in_acc;
  logic s1_adv;

  // stage 1 advances when the output register is free or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic [1:0]  s1_op_r;
  logic [15:0] s1_iw_r;
  logic [15:0] s1_e1_r;
  logic [15:0] s1_e2_r;
  logic [31:0] s1_pc_r;
  logic [15:0] s1_md_r;
  logic [4:0]  s1_ri_r;
  logic [31:0] s1_rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_opcode;
      s1_iw_r <= in_instr_word;
      s1_e1_r <= in_ext_word_first;
      s1_e2_r <= in_ext_word_second;
      s1_pc_r <= in_ext_addr;
      s1_md_r <= in_mem_data;
      s1_ri_r <= in_reg_index;
      s1_rv_r <= in_reg_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Register file: D0-D7 then A0-A7, one write port, two registered reads.
  // Read A serves Dn (data register direct) or An; read B the brief index reg.
  // ---------------------------------------------------------------------------
  logic [31:0] rf_mem [16];
  logic [15:0] rf_vld_r;
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        rf_wr;
  logic [3:0]  rd_a_addr;
  logic [3:0]  rd_b_addr;
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  assign rf_wr     = s1_adv && rf_we;
  assign rd_a_addr = {in_instr_word[5:3] != EA_DREG, in_instr_word[2:0]};
  assign rd_b_addr = {in_ext_word_first[15], in_ext_word_first[14:12]};

  always_ff @(posedge clk) begin
    if (rf_wr) begin
      rf_mem[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_wr) begin
      rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  // reads see a write retiring on the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (rf_wr && rf_wa == rd_a_addr) begin
        rd_a_r <= rf_wd;
      end else if (rf_vld_r[rd_a_addr]) begin
        rd_a_r <= rf_mem[rd_a_addr];
      end else begin
        rd_a_r <= '0;
      end
      if (rf_wr && rf_wa == rd_b_addr) begin
        rd_b_r <= rf_wd;
      end else if (rf_vld_r[rd_b_addr]) begin
        rd_b_r <= rf_mem[rd_b_addr];
      end else begin
        rd_b_r <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state besides the register file
  // ---------------------------------------------------------------------------
  logic [4:0]  cc_r, cc_nxt;
  logic        await_r, await_nxt;
  logic [2:0]  pdest_r, pdest_nxt;
  logic [1:0]  pmode_r, pmode_nxt;
  logic [31:0] ppc_r, ppc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= '0;
      await_r <= 1'b0;
      pdest_r <= '0;
      pmode_r <= '0;
      ppc_r   <= '0;
    end else if (s1_adv) begin
      cc_r    <= cc_nxt;
      await_r <= await_nxt;
      pdest_r <= pdest_nxt;
      pmode_r <= pmode_nxt;
      ppc_r   <= ppc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and address generation
  // ---------------------------------------------------------------------------
  logic [2:0]  dx;
  logic [1:0]  om;
  logic [2:0]  ea_mode;
  logic [2:0]  rn;
  logic        is_byte;
  logic [31:0] step;
  logic [31:0] an_inc;
  logic [31:0] an_dec;
  logic [31:0] rel_base;
  logic [31:0] disp_addr;
  logic [31:0] idx_ext;
  logic [31:0] idx_scaled;
  logic [31:0] idx_addr;

  assign dx      = s1_iw_r[11:9];
  assign om      = s1_iw_r[7:6];
  assign ea_mode = s1_iw_r[5:3];
  assign rn      = s1_iw_r[2:0];
  assign is_byte = (om == EXT_MVS_B) || (om == EXT_MVZ_B);
  // A7 keeps word alignment for byte steps
  assign step    = (is_byte && rn != 3'd7) ? 32'd1 : 32'd2;
  assign an_inc  = rd_a_r + step;
  assign an_dec  = rd_a_r - step;

  // base is An for its own modes, the extension-word pc for pc-relative
  assign rel_base   = (ea_mode == EA_SPECIAL) ? s1_pc_r : rd_a_r;
  assign disp_addr  = rel_base + sx16(s1_e1_r);
  assign idx_ext    = s1_e1_r[11] ? rd_b_r : sx16(rd_b_r[15:0]);
  assign idx_scaled = idx_ext << s1_e1_r[10:9];
  assign idx_addr   = rel_base + idx_scaled + sx8(s1_e1_r[7:0]);

  // ---------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------
  status_t     st;
  logic [31:0] r_mem_addr;
  logic        r_mem_byte;
  logic [2:0]  r_dreg;
  logic [31:0] r_dval;
  logic [31:0] r_npc;
  logic [2:0]  r_ar_idx;
  logic [31:0] r_ar_val;
  logic        r_ar_chg;
  logic        fin_en;
  logic [2:0]  fin_dest;
  logic [1:0]  fin_mode;
  logic [31:0] fin_src;
  logic [31:0] fin_val;
  logic        mem_req;
  logic [31:0] ea_addr;
  logic [31:0] npc;

  assign fin_val = extend_value(fin_mode, fin_src);

  always_comb begin
    st         = ST_IGNORED;
    r_mem_addr = '0;
    r_mem_byte = 1'b0;
    r_dreg     = '0;
    r_dval     = '0;
    r_npc      = '0;
    r_ar_idx   = '0;
    r_ar_val   = '0;
    r_ar_chg   = 1'b0;
    cc_nxt     = cc_r;
    await_nxt  = await_r;
    pdest_nxt  = pdest_r;
    pmode_nxt  = pmode_r;
    ppc_nxt    = ppc_r;
    rf_we      = 1'b0;
    rf_wa      = '0;
    rf_wd      = '0;
    fin_en     = 1'b0;
    fin_dest   = dx;
    fin_mode   = om;
    fin_src    = rd_a_r;
    mem_req    = 1'b0;
    ea_addr    = rd_a_r;
    npc        = s1_pc_r;

    unique case (s1_op_r)
      OP_WRITE_REG: begin
        if (!s1_ri_r[4]) begin
          rf_we = 1'b1;
          rf_wa = s1_ri_r[3:0];
          rf_wd = s1_rv_r;
          st    = ST_REG_WRITTEN;
        end else if (s1_ri_r == REG_INDEX_CC) begin
          cc_nxt = s1_rv_r[4:0];
          st     = ST_REG_WRITTEN;
        end
      end
      OP_DATA_RETURN: begin
        if (await_r) begin
          await_nxt = 1'b0;
          fin_en    = 1'b1;
          fin_dest  = pdest_r;
          fin_mode  = pmode_r;
          fin_src   = {16'd0, s1_md_r};
          npc       = ppc_r;
        end
      end
      OP_EXECUTE: begin
        if (!await_r) begin
          if ((s1_iw_r & OPC_MASK) != OPC_MATCH) begin
            st = ST_UNHANDLED;
          end else begin
            unique case (ea_mode)
              EA_DREG: begin
                fin_en = 1'b1;
              end
              EA_IND: begin
                mem_req = 1'b1;
              end
              EA_POSTINC: begin
                mem_req  = 1'b1;
                rf_we    = 1'b1;
                rf_wa    = {1'b1, rn};
                rf_wd    = an_inc;
                r_ar_idx = rn;
                r_ar_val = an_inc;
                r_ar_chg = 1'b1;
              end
              EA_PREDEC: begin
                mem_req  = 1'b1;
                ea_addr  = an_dec;
                rf_we    = 1'b1;
                rf_wa    = {1'b1, rn};
                rf_wd    = an_dec;
                r_ar_idx = rn;
                r_ar_val = an_dec;
                r_ar_chg = 1'b1;
              end
              EA_DISP: begin
                mem_req = 1'b1;
                ea_addr = disp_addr;
                npc     = s1_pc_r + 32'd2;
              end
              EA_INDEX: begin
                mem_req = 1'b1;
                ea_addr = idx_addr;
                npc     = s1_pc_r + 32'd2;
              end
              EA_SPECIAL: begin
                unique case (rn)
                  EA7_ABS_W: begin
                    mem_req = 1'b1;
                    ea_addr = sx16(s1_e1_r);
                    npc     = s1_pc_r + 32'd2;
                  end
                  EA7_ABS_L: begin
                    mem_req = 1'b1;
                    ea_addr = {s1_e1_r, s1_e2_r};
                    npc     = s1_pc_r + 32'd4;
                  end
                  EA7_PC_DISP: begin
                    mem_req = 1'b1;
                    ea_addr = disp_addr;
                    npc     = s1_pc_r + 32'd2;
                  end
                  EA7_PC_INDEX: begin
                    mem_req = 1'b1;
                    ea_addr = idx_addr;
                    npc     = s1_pc_r + 32'd2;
                  end
                  EA7_IMM: begin
                    fin_en  = 1'b1;
                    fin_src = {16'd0, s1_e1_r};
                    npc     = s1_pc_r + 32'd2;
                  end
                  default: begin
                    st = ST_UNHANDLED;
                  end
                endcase
              end
              default: begin
                // address register direct
                st = ST_UNHANDLED;
              end
            endcase
          end
        end
      end
      default: begin
        st = ST_IGNORED;
      end
    endcase

    if (fin_en) begin
      rf_we  = 1'b1;
      rf_wa  = {1'b0, fin_dest};
      rf_wd  = fin_val;
      cc_nxt = {cc_r[CC_X_BIT], fin_val[31], fin_val == 32'd0, 2'b00};
      st     = ST_DONE;
      r_dreg = fin_dest;
      r_dval = fin_val;
      r_npc  = npc;
    end

    if (mem_req) begin
      await_nxt  = 1'b1;
      pdest_nxt  = dx;
      pmode_nxt  = om;
      ppc_nxt    = npc;
      st         = ST_MEM_READ;
      r_mem_addr = ea_addr;
      r_mem_byte = is_byte;
      r_npc      = npc;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  status_t     out_status_r;
  logic [31:0] out_mem_address_r;
  logic        out_mem_byte_r;
  logic [2:0]  out_dest_reg_r;
  logic [31:0] out_dest_value_r;
  logic [4:0]  out_cond_codes_r;
  logic [31:0] out_next_pc_r;
  logic [2:0]  out_ar_idx_r;
  logic [31:0] out_ar_val_r;
  logic        out_ar_chg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r      <= st;
      out_mem_address_r <= r_mem_addr;
      out_mem_byte_r    <= r_mem_byte;
      out_dest_reg_r    <= r_dreg;
      out_dest_value_r  <= r_dval;
      out_cond_codes_r  <= cc_nxt;
      out_next_pc_r     <= r_npc;
      out_ar_idx_r      <= r_ar_idx;
      out_ar_val_r      <= r_ar_val;
      out_ar_chg_r      <= r_ar_chg;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_mem_address      = out_mem_address_r;
  assign out_mem_byte         = out_mem_byte_r;
  assign out_dest_reg         = out_dest_reg_r;
  assign out_dest_value       = out_dest_value_r;
  assign out_cond_codes       = out_cond_codes_r;
  assign out_next_pc          = out_next_pc_r;
  assign out_addr_reg_index   = out_ar_idx_r;
  assign out_addr_reg_value   = out_ar_val_r;
  assign out_addr_reg_changed = out_ar_chg_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a read request on display means the unit is waiting for its data
  `MWEU_ASSERT_IMPLY(a_req_pending, clk, rst_n,
    out_valid_r && out_status_r == ST_MEM_READ, await_r)
  // an instruction arriving while data is outstanding is dropped
  `MWEU_ASSERT_NEXT(a_exec_while_wait, clk, rst_n,
    s1_adv && await_r && s1_op_r == OP_EXECUTE, out_status_r == ST_IGNORED)
  // address register updates come only with a memory read
  `MWEU_ASSERT_IMPLY(a_an_update_with_read, clk, rst_n,
    out_valid_r && out_ar_chg_r, out_status_r == ST_MEM_READ)

endmodule

`default_nettype wire
